/* rtl/core/iep_pkg.sv */
// ----------------------------------------------------------------------------
// iep_pkg
// Shared types, constants and helpers of the interval event profiler.
// ----------------------------------------------------------------------------
package iep_pkg;

	localparam int PAIR_SLOTS  = 4;
	localparam int CALL_SLOTS  = 32;
	localparam int IPC_SLOTS   = 8;
	localparam int TOTAL_SLOTS = PAIR_SLOTS + CALL_SLOTS + IPC_SLOTS;
	localparam int SLOT_W      = $clog2(TOTAL_SLOTS);
	localparam int CFG_IDX_W   = 3;
	localparam int FIFO_DEPTH  = 2;
	localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);

	localparam logic [19:0] USEC_PER_SEC = 20'd1000000;
	localparam logic [31:0] COUNT_MAX    = 32'hffffffff;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ENABLE     = 3'd0,
		REG_PAIR_START = 3'd1,
		REG_PAIR_STOP  = 3'd2,
		REG_CALL_BASE  = 3'd3,
		REG_CALL_END   = 3'd4,
		REG_IPC_BASE   = 3'd5,
		REG_IPC_END    = 3'd6,
		REG_TPS        = 3'd7
	} cfg_idx_t;

	typedef struct packed {
		logic        enable;
		logic [31:0] pair_start;
		logic [31:0] pair_stop;
		logic [7:0]  call_base;
		logic [7:0]  call_end;
		logic [7:0]  ipc_base;
		logic [7:0]  ipc_end;
		logic [63:0] tps;
	} cfg_t;

	// event queued between front and back
	typedef struct packed {
		logic [7:0]  code;
		logic [63:0] now;
		logic [63:0] first;
	} evt_ent_t;

	// per-slot statistics record
	typedef struct packed {
		logic [63:0] start;
		logic [63:0] sum;
		logic [31:0] cnt;
		logic [63:0] min;
		logic [63:0] max;
	} slot_rec_t;

	localparam slot_rec_t REC_RESET = '{start: '0, sum: '0, cnt: '0, min: '1, max: '0};

	typedef struct packed {
		logic [5:0]  slot;
		logic        last;
		logic [63:0] delta;
		logic [31:0] cnt;
		logic [63:0] avg;
		logic [63:0] tot;
		logic [63:0] min;
		logic [63:0] max;
		logic [63:0] first;
		logic [63:0] latest;
	} res_t;

	typedef enum logic [3:0] {
		B_IDLE, B_RD, B_EVAL, B_ACC, B_DS, B_DQ, B_ML, B_MH, B_MA, B_DV,
		B_UPD, B_WR, B_PUSH, B_NEXT, B_FIN
	} back_state_t;

	// conversion step sequence
	typedef enum logic [1:0] {
		CV_AVG,
		CV_TOT,
		CV_DU
	} conv_t;

	// start code in [15:8], stop code in [7:0]
	function automatic logic [15:0] slot_codes(cfg_t c, logic [SLOT_W-1:0] s);
		logic [7:0] sc;
		logic [7:0] ec;
		logic [7:0] s8;
		s8 = 8'(s);
		if (s8 < 8'(PAIR_SLOTS)) begin
			sc = c.pair_start[{s[1:0], 3'b000} +: 8];
			ec = c.pair_stop[{s[1:0], 3'b000} +: 8];
		end else if (s8 < 8'(PAIR_SLOTS + CALL_SLOTS)) begin
			sc = c.call_base + (s8 - 8'(PAIR_SLOTS));
			ec = c.call_end;
		end else begin
			sc = c.ipc_base + (s8 - 8'(PAIR_SLOTS + CALL_SLOTS));
			ec = c.ipc_end;
		end
		return {sc, ec};
	endfunction

endpackage

/* rtl/core/iep_if.sv */
// ----------------------------------------------------------------------------
// iep_if
// Event and result channels of the interval event profiler.
// ----------------------------------------------------------------------------
interface iep_evt_if;
	logic        valid;
	logic        ready;
	logic [7:0]  event_code;
	logic [63:0] event_time;
	modport source(output valid, event_code, event_time, input ready);
	modport sink(input valid, event_code, event_time, output ready);
endinterface

interface iep_res_if;
	logic        valid;
	logic        ready;
	logic [5:0]  slot;
	logic        last;
	logic [63:0] span_usec;
	logic [31:0] sample_count;
	logic [63:0] average_usec;
	logic [63:0] total_usec;
	logic [63:0] min_usec;
	logic [63:0] max_usec;
	logic [63:0] first_event_time;
	logic [63:0] last_event_time;
	modport source(output valid, slot, last, span_usec, sample_count, average_usec,
		total_usec, min_usec, max_usec, first_event_time, last_event_time, input ready);
	modport sink(input valid, slot, last, span_usec, sample_count, average_usec,
		total_usec, min_usec, max_usec, first_event_time, last_event_time, output ready);
endinterface

/* rtl/core/iep_front.sv */
// ----------------------------------------------------------------------------
// iep_front
// Accepts events, drops them while disabled, tracks the first event time
// and queues enabled events for the slot walk.
// ----------------------------------------------------------------------------
module iep_front (
	input  logic              clk,
	input  logic              arst_n,
	iep_evt_if.sink           evt,
	input  logic              enable,
	input  logic              full,
	output logic              push,
	output iep_pkg::evt_ent_t push_ent
);
	import iep_pkg::*;

	logic [63:0] first_q;
	logic [63:0] first_d;
	logic        accept;

	// accept whenever the queue has room
	assign evt.ready = !full;
	assign accept    = evt.valid && evt.ready;
	assign first_d   = (first_q == 64'd0) ? evt.event_time : first_q;
	assign push      = accept && enable;
	assign push_ent  = '{code: evt.event_code, now: evt.event_time, first: first_d};

	// hold the first time seen while enabled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= '0;
		end else if (push) begin
			first_q <= first_d;
		end
	end

endmodule

/* rtl/core/iep_fifo.sv */
// ----------------------------------------------------------------------------
// iep_fifo
// Short event queue between front and back.
// ----------------------------------------------------------------------------
module iep_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  iep_pkg::evt_ent_t din,
	output logic              full,
	input  logic              pop,
	output iep_pkg::evt_ent_t dout,
	output logic              empty
);
	import iep_pkg::*;

	evt_ent_t                mem [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0]   wr_q;
	logic [FIFO_PTR_W-1:0]   rd_q;
	logic [FIFO_PTR_W:0]     cnt_q;

	assign full  = (cnt_q == (FIFO_PTR_W + 1)'(FIFO_DEPTH));
	assign empty = (cnt_q == '0);
	assign dout  = mem[rd_q];

	// store entries
	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_q] <= din;
		end
	end

	// advance pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			cnt_q <= cnt_q + (FIFO_PTR_W + 1)'(push) - (FIFO_PTR_W + 1)'(pop);
		end
	end

endmodule

/* rtl/core/iep_div.sv */
// ----------------------------------------------------------------------------
// iep_div
// 64-bit unsigned restoring divider, one quotient bit per cycle.
// A zero divisor yields an all-ones quotient.
// ----------------------------------------------------------------------------
module iep_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] dividend,
	input  logic [63:0] divisor,
	output logic        done,
	output logic [63:0] quotient
);
	logic [63:0] rem_q;
	logic [63:0] quo_q;
	logic [63:0] den_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [64:0] trial;
	logic        fits;

	assign trial    = {rem_q, quo_q[63]};
	assign fits     = trial >= {1'b0, den_q};
	assign done     = done_q;
	assign quotient = quo_q;

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			den_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? 64'(trial - {1'b0, den_q}) : trial[63:0];
			quo_q <= {quo_q[62:0], fits};
		end
	end

	// step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

/* rtl/core/iep_back.sv */
// ----------------------------------------------------------------------------
// iep_back
// Walks all slots for each queued event, updates slot statistics in the
// slot store and emits one result per closed interval.
// ----------------------------------------------------------------------------
module iep_back (
	input  logic              clk,
	input  logic              arst_n,
	input  iep_pkg::cfg_t     cfg,
	input  logic              empty,
	input  iep_pkg::evt_ent_t ent,
	output logic              pop,
	iep_res_if.source         res
);
	import iep_pkg::*;

	back_state_t state_q, state_d;

	slot_rec_t              mem [TOTAL_SLOTS];
	logic [TOTAL_SLOTS-1:0] vld_q;
	slot_rec_t              rd_q;
	logic                   rd_vld_q;
	logic [SLOT_W-1:0]      slot_q;
	evt_ent_t               cur_q;

	logic [63:0] delta_q, sum_q, min_q, max_q;
	logic [31:0] cnt_q;
	logic [63:0] avg_q, tot_q, du_q, src_q, plo_q;
	logic [31:0] phi_q;
	conv_t       conv_q;
	res_t        pend_q, out_q;
	logic        pend_vld_q, out_vld_q;

	slot_rec_t   rec, wdata;
	logic        mem_we;
	logic [15:0] codes;
	logic        is_start, is_stop, out_free, out_load;
	logic [63:0] prod_sum;
	logic        dv_start, dv_done;
	logic [63:0] dv_dividend, dv_divisor, dv_quot;
	res_t        new_res;
	res_t        out_d;

	iep_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (dv_start),
		.dividend (dv_dividend),
		.divisor  (dv_divisor),
		.done     (dv_done),
		.quotient (dv_quot)
	);

	assign rec      = rd_vld_q ? rd_q : REC_RESET;
	assign codes    = slot_codes(cfg, slot_q);
	assign is_start = cur_q.code == codes[15:8];
	assign is_stop  = !is_start && (cur_q.code == codes[7:0]) && (rec.start != 64'd0);
	assign out_free = !out_vld_q || res.ready;
	assign prod_sum = plo_q + {phi_q, 32'd0};
	assign new_res  = '{slot: 6'(slot_q), last: 1'b0, delta: du_q, cnt: cnt_q, avg: avg_q,
		tot: tot_q, min: min_q, max: max_q, first: cur_q.first, latest: cur_q.now};

	// mark the flush at the end of the walk as the final result
	always_comb begin
		out_d      = pend_q;
		out_d.last = (state_q == B_FIN);
	end

	// next state and control
	always_comb begin
		state_d     = state_q;
		pop         = 1'b0;
		mem_we      = 1'b0;
		wdata       = rec;
		dv_start    = 1'b0;
		dv_dividend = sum_q;
		dv_divisor  = {32'd0, cnt_q};
		out_load    = 1'b0;
		case (state_q)
			B_IDLE: begin
				if (!empty) begin
					pop     = 1'b1;
					state_d = B_RD;
				end
			end
			B_RD: state_d = B_EVAL;
			B_EVAL: begin
				if (is_start) begin
					mem_we      = 1'b1;
					wdata.start = cur_q.now;
					state_d     = B_NEXT;
				end else if (is_stop) begin
					state_d = B_ACC;
				end else begin
					state_d = B_NEXT;
				end
			end
			B_ACC: state_d = B_DS;
			B_DS: begin
				dv_start = 1'b1;
				state_d  = B_DQ;
			end
			B_DQ: begin
				if (dv_done) begin
					state_d = B_ML;
				end
			end
			B_ML: state_d = B_MH;
			B_MH: state_d = B_MA;
			B_MA: begin
				dv_start    = 1'b1;
				dv_dividend = prod_sum;
				dv_divisor  = cfg.tps;
				state_d     = B_DV;
			end
			B_DV: begin
				if (dv_done) begin
					state_d = (conv_q == CV_DU) ? B_UPD : B_ML;
				end
			end
			B_UPD: state_d = B_WR;
			B_WR: begin
				mem_we  = 1'b1;
				wdata   = '{start: '0, sum: sum_q, cnt: cnt_q, min: min_q, max: max_q};
				state_d = B_PUSH;
			end
			B_PUSH: begin
				if (!pend_vld_q) begin
					state_d = B_NEXT;
				end else if (out_free) begin
					out_load = 1'b1;
					state_d  = B_NEXT;
				end
			end
			B_NEXT: begin
				state_d = (slot_q == SLOT_W'(TOTAL_SLOTS - 1)) ? B_FIN : B_RD;
			end
			B_FIN: begin
				if (!pend_vld_q) begin
					state_d = B_IDLE;
				end else if (out_free) begin
					out_load = 1'b1;
					state_d  = B_IDLE;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// slot store, read every cycle at the current slot
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[slot_q] <= wdata;
		end
		rd_q <= mem[slot_q];
	end

	// entry valid bits: an unwritten slot reads as its reset record
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (mem_we) begin
				vld_q[slot_q] <= 1'b1;
			end
			rd_vld_q <= vld_q[slot_q];
		end
	end

	// walk and arithmetic datapath
	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				cur_q  <= ent;
				slot_q <= '0;
			end
			B_EVAL: delta_q <= cur_q.now - rec.start;
			B_ACC: begin
				sum_q <= rec.sum + delta_q;
				cnt_q <= (rec.cnt != COUNT_MAX) ? rec.cnt + 32'd1 : rec.cnt;
				min_q <= rec.min;
				max_q <= rec.max;
			end
			B_DQ: begin
				src_q  <= dv_quot;
				conv_q <= CV_AVG;
			end
			B_ML: plo_q <= 64'(src_q[31:0] * USEC_PER_SEC);
			B_MH: phi_q <= 32'(src_q[63:32] * USEC_PER_SEC);
			B_DV: begin
				if (dv_done) begin
					case (conv_q)
						CV_AVG: begin
							avg_q  <= dv_quot;
							src_q  <= sum_q;
							conv_q <= CV_TOT;
						end
						CV_TOT: begin
							tot_q  <= dv_quot;
							src_q  <= delta_q;
							conv_q <= CV_DU;
						end
						default: du_q <= dv_quot;
					endcase
				end
			end
			B_UPD: begin
				if (du_q < min_q) min_q <= du_q;
				if (du_q > max_q) max_q <= du_q;
			end
			B_PUSH: begin
				if (!pend_vld_q || out_free) begin
					pend_q <= new_res;
				end
			end
			B_NEXT: slot_q <= slot_q + 1'b1;
			default: ;
		endcase
		if (out_load) begin
			out_q <= out_d;
		end
	end

	// hold the pending result until the next close or the end of the walk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_vld_q <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			if (state_q == B_PUSH && (!pend_vld_q || out_free)) begin
				pend_vld_q <= 1'b1;
			end else if (state_q == B_FIN && out_load) begin
				pend_vld_q <= 1'b0;
			end
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (res.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	assign res.valid            = out_vld_q;
	assign res.slot             = out_q.slot;
	assign res.last             = out_q.last;
	assign res.span_usec        = out_q.delta;
	assign res.sample_count     = out_q.cnt;
	assign res.average_usec     = out_q.avg;
	assign res.total_usec       = out_q.tot;
	assign res.min_usec         = out_q.min;
	assign res.max_usec         = out_q.max;
	assign res.first_event_time = out_q.first;
	assign res.last_event_time  = out_q.latest;

endmodule

/* rtl/core/interval_event_profiler_unit.sv */
// ----------------------------------------------------------------------------
// interval_event_profiler_unit
// Start/stop interval statistics over pair, call and ipc slots.
//
//   channel  dir  handshake          payload
//   evt      in   valid/ready        event_code, event_time
//   res      out  valid/ready        slot, last, usec statistics, times
//   cfg      in   cfg_we             cfg_idx, cfg_wdata
//
// Each event walks all 44 slots; each closed interval adds four divisions
// in the shared bit-serial divider. A two-entry queue lets the front keep
// accepting while the back walks. The result register drains independently;
// a full register stalls the walk. Reset clears all slots at once.
// ----------------------------------------------------------------------------
module interval_event_profiler_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	iep_evt_if.sink                        evt,
	iep_res_if.source                      res,
	input  logic                           cfg_we,
	input  logic [iep_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [63:0]                    cfg_wdata
);
	import iep_pkg::*;

	cfg_t     cfg_q;
	logic     push, full, pop, empty;
	evt_ent_t push_ent, pop_ent;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{enable: 1'b0, pair_start: '0, pair_stop: '0, call_base: '0,
				call_end: '0, ipc_base: '0, ipc_end: '0, tps: 64'(USEC_PER_SEC)};
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_idx))
				REG_ENABLE:     cfg_q.enable     <= cfg_wdata[0];
				REG_PAIR_START: cfg_q.pair_start <= cfg_wdata[31:0];
				REG_PAIR_STOP:  cfg_q.pair_stop  <= cfg_wdata[31:0];
				REG_CALL_BASE:  cfg_q.call_base  <= cfg_wdata[7:0];
				REG_CALL_END:   cfg_q.call_end   <= cfg_wdata[7:0];
				REG_IPC_BASE:   cfg_q.ipc_base   <= cfg_wdata[7:0];
				REG_IPC_END:    cfg_q.ipc_end    <= cfg_wdata[7:0];
				REG_TPS:        cfg_q.tps        <= cfg_wdata;
				default: ;
			endcase
		end
	end

	iep_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.evt      (evt),
		.enable   (cfg_q.enable),
		.full     (full),
		.push     (push),
		.push_ent (push_ent)
	);

	iep_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (push_ent),
		.full   (full),
		.pop    (pop),
		.dout   (pop_ent),
		.empty  (empty)
	);

	iep_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.empty  (empty),
		.ent    (pop_ent),
		.pop    (pop),
		.res    (res)
	);

endmodule

/* dv/interval_event_profiler_unit_test.sv */
// ----------------------------------------------------------------------------
// interval_event_profiler_unit_test
// Self-checking bench for the interval event profiler. A driver and monitors
// run as clocked processes; an in-bench predictor keeps its own copy of the
// slot statistics and checks every result transaction field by field.
// ----------------------------------------------------------------------------
module interval_event_profiler_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	import iep_pkg::*;

	localparam int IDLE_SETTLE = 800;
	localparam int LONG_HOLD   = 3000;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [63:0] cfg_wdata;

	iep_evt_if evt();
	iep_res_if res();

	interval_event_profiler_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.evt       (evt),
		.res       (res),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	typedef struct {
		logic [7:0]  code;
		logic [63:0] stamp;
	} trace_evt_t;

	// shadow configuration and slot statistics
	cfg_t        shadow_cfg;
	slot_rec_t   shadow_slot [TOTAL_SLOTS];
	logic [63:0] shadow_first;
	logic [63:0] shadow_latest;

	trace_evt_t  pending_evts [$];
	res_t        expected_stats_q [$];

	int unsigned mismatch_cnt;
	int unsigned stats_seen;
	int unsigned evts_accepted;
	int unsigned ignored_cnt;
	logic [63:0] tick_now;

	// clock
	initial clk = 1'b0;
	always #4 clk = ~clk;

	// convert ticks to microseconds with 64-bit wrap on the product
	function automatic logic [63:0] ticks_to_usec(logic [63:0] ticks);
		logic [63:0] prod;
		if (shadow_cfg.tps == 64'd0)
			return '1;
		prod = ticks * 64'd1000000;
		return prod / shadow_cfg.tps;
	endfunction

	function automatic logic [7:0] start_code_of(int s);
		if (s < PAIR_SLOTS)
			return shadow_cfg.pair_start[8*s +: 8];
		else if (s < PAIR_SLOTS + CALL_SLOTS)
			return shadow_cfg.call_base + 8'(s - PAIR_SLOTS);
		return shadow_cfg.ipc_base + 8'(s - PAIR_SLOTS - CALL_SLOTS);
	endfunction

	function automatic logic [7:0] stop_code_of(int s);
		if (s < PAIR_SLOTS)
			return shadow_cfg.pair_stop[8*s +: 8];
		else if (s < PAIR_SLOTS + CALL_SLOTS)
			return shadow_cfg.call_end;
		return shadow_cfg.ipc_end;
	endfunction

	// apply one event to the shadow state and queue the closed intervals
	function automatic void profile_event(logic [7:0] code, logic [63:0] stamp);
		res_t        r;
		logic [63:0] delta;
		int          first_idx;
		first_idx = expected_stats_q.size();
		if (!shadow_cfg.enable) begin
			ignored_cnt++;
			return;
		end
		if (shadow_first == 64'd0)
			shadow_first = stamp;
		shadow_latest = stamp;
		for (int s = 0; s < TOTAL_SLOTS; s++) begin
			if (code == start_code_of(s)) begin
				shadow_slot[s].start = stamp;
			end else if (code == stop_code_of(s) && shadow_slot[s].start != 64'd0) begin
				delta = stamp - shadow_slot[s].start;
				shadow_slot[s].sum += delta;
				if (shadow_slot[s].cnt != 32'hffffffff)
					shadow_slot[s].cnt++;
				r.slot   = 6'(s);
				r.last   = 1'b0;
				r.delta  = ticks_to_usec(delta);
				r.cnt    = shadow_slot[s].cnt;
				r.avg    = ticks_to_usec(shadow_slot[s].sum / {32'd0, shadow_slot[s].cnt});
				r.tot    = ticks_to_usec(shadow_slot[s].sum);
				if (r.delta < shadow_slot[s].min)
					shadow_slot[s].min = r.delta;
				if (r.delta > shadow_slot[s].max)
					shadow_slot[s].max = r.delta;
				r.min    = shadow_slot[s].min;
				r.max    = shadow_slot[s].max;
				r.first  = shadow_first;
				r.latest = shadow_latest;
				shadow_slot[s].start = 64'd0;
				expected_stats_q.push_back(r);
			end
		end
		if (expected_stats_q.size() > first_idx)
			expected_stats_q[$].last = 1'b1;
	endfunction

	function automatic void check_field(string name, int s, logic [63:0] exp_v,
			logic [63:0] act_v);
		if (exp_v !== act_v) begin
			mismatch_cnt++;
			if (mismatch_cnt <= 10)
				$display("[%0t] slot %0d %s: expected %h, got %h", $time, s, name, exp_v, act_v);
		end
	endfunction

	// input driver: bursts of random length separated by random gaps
	int burst_left;
	int gap_left;
	always @(posedge clk or negedge arst_n) begin
		trace_evt_t e;
		if (!arst_n) begin
			evt.valid      <= 1'b0;
			evt.event_code <= 8'd0;
			evt.event_time <= 64'd0;
			burst_left     <= 0;
			gap_left       <= 0;
		end else if (!(evt.valid && !evt.ready)) begin
			if (gap_left > 0) begin
				evt.valid <= 1'b0;
				gap_left  <= gap_left - 1;
			end else if (pending_evts.size() > 0) begin
				e = pending_evts.pop_front();
				evt.valid      <= 1'b1;
				evt.event_code <= e.code;
				evt.event_time <= e.stamp;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 16);
					gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				evt.valid <= 1'b0;
			end
		end
	end

	// predict on every accepted event transaction
	always @(posedge clk) begin
		if (arst_n && evt.valid && evt.ready) begin
			evts_accepted++;
			profile_event(evt.event_code, evt.event_time);
		end
	end

	// result sink: own stall pattern plus one long hold-off
	int  hold_left;
	int  mode_left;
	int  ready_pct;
	bit  long_done;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res.ready <= 1'b0;
			hold_left <= 0;
			mode_left <= 0;
			ready_pct <= 100;
			long_done <= 1'b0;
		end else if (hold_left > 0) begin
			res.ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (!long_done && stats_seen >= 40) begin
			res.ready <= 1'b0;
			hold_left <= LONG_HOLD;
			long_done <= 1'b1;
		end else begin
			if (mode_left == 0) begin
				mode_left <= $urandom_range(50, 300);
				case ($urandom_range(0, 2))
					0: ready_pct <= 100;
					1: ready_pct <= 70;
					default: ready_pct <= 30;
				endcase
			end else begin
				mode_left <= mode_left - 1;
			end
			res.ready <= ($urandom_range(1, 100) <= ready_pct);
		end
	end

	// compare each result transaction with the oldest expectation
	always @(posedge clk) begin
		res_t x;
		if (arst_n && res.valid && res.ready) begin
			stats_seen++;
			if (expected_stats_q.size() == 0) begin
				mismatch_cnt++;
				if (mismatch_cnt <= 10)
					$display("[%0t] unexpected result for slot %0d", $time, res.slot);
			end else begin
				x = expected_stats_q.pop_front();
				check_field("slot", x.slot, 64'(x.slot), 64'(res.slot));
				check_field("last", x.slot, 64'(x.last), 64'(res.last));
				check_field("span_usec", x.slot, x.delta, res.span_usec);
				check_field("sample_count", x.slot, 64'(x.cnt), 64'(res.sample_count));
				check_field("average_usec", x.slot, x.avg, res.average_usec);
				check_field("total_usec", x.slot, x.tot, res.total_usec);
				check_field("min_usec", x.slot, x.min, res.min_usec);
				check_field("max_usec", x.slot, x.max, res.max_usec);
				check_field("first_event_time", x.slot, x.first, res.first_event_time);
				check_field("last_event_time", x.slot, x.latest, res.last_event_time);
			end
		end
	end

	// configuration write: hold enable across back-to-back writes
	task automatic write_reg(cfg_idx_t idx, logic [63:0] data);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= data;
		case (idx)
			REG_ENABLE:     shadow_cfg.enable     = data[0];
			REG_PAIR_START: shadow_cfg.pair_start = data[31:0];
			REG_PAIR_STOP:  shadow_cfg.pair_stop  = data[31:0];
			REG_CALL_BASE:  shadow_cfg.call_base  = data[7:0];
			REG_CALL_END:   shadow_cfg.call_end   = data[7:0];
			REG_IPC_BASE:   shadow_cfg.ipc_base   = data[7:0];
			REG_IPC_END:    shadow_cfg.ipc_end    = data[7:0];
			default:        shadow_cfg.tps        = data;
		endcase
	endtask

	task automatic end_writes();
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// wait until all events are taken and all results are in, then settle
	task automatic wait_idle();
		do begin
			wait (pending_evts.size() == 0 && !evt.valid && expected_stats_q.size() == 0);
			repeat (IDLE_SETTLE) @(posedge clk);
		end while (expected_stats_q.size() != 0 || pending_evts.size() != 0);
	endtask

	function automatic void push_evt(logic [7:0] code, logic [63:0] stamp);
		trace_evt_t e;
		e.code  = code;
		e.stamp = stamp;
		pending_evts.push_back(e);
	endfunction

	function automatic logic [63:0] next_tick();
		tick_now += 64'($urandom_range(1, 5000));
		return tick_now;
	endfunction

	// mostly well-formed start/stop traffic, some noise and odd times
	function automatic void push_random(int n);
		int          r;
		int          s;
		logic [63:0] t;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			s = $urandom_range(0, TOTAL_SLOTS - 1);
			t = next_tick();
			if (r >= 92)
				t = {$urandom, $urandom};
			else if (r >= 90)
				t = ($urandom_range(0, 1) == 0) ? 64'd0 : '1;
			if (r < 35)
				push_evt(start_code_of(s), t);
			else if (r < 55)
				push_evt(shadow_cfg.pair_stop[8*$urandom_range(0, 3) +: 8], t);
			else if (r < 65)
				push_evt(shadow_cfg.call_end, t);
			else if (r < 75)
				push_evt(shadow_cfg.ipc_end, t);
			else
				push_evt(8'($urandom), t);
		end
	endfunction

	task automatic random_config(logic [63:0] tps);
		write_reg(REG_PAIR_START, 64'($urandom));
		write_reg(REG_PAIR_STOP, 64'($urandom));
		write_reg(REG_CALL_BASE, 64'($urandom_range(0, 255)));
		write_reg(REG_CALL_END, 64'($urandom_range(0, 255)));
		write_reg(REG_IPC_BASE, 64'($urandom_range(0, 255)));
		write_reg(REG_IPC_END, 64'($urandom_range(0, 255)));
		write_reg(REG_TPS, tps);
		end_writes();
	endtask

	// stimulus and phases
	initial begin
		cfg_we     = 1'b0;
		cfg_idx    = REG_ENABLE;
		cfg_wdata  = 64'd0;
		arst_n     = 1'b0;
		tick_now   = 64'd1000;
		shadow_cfg = '{enable: 1'b0, pair_start: '0, pair_stop: '0, call_base: '0,
			call_end: '0, ipc_base: '0, ipc_end: '0, tps: 64'd1000000};
		for (int s = 0; s < TOTAL_SLOTS; s++)
			shadow_slot[s] = REC_RESET;
		shadow_first  = 64'd0;
		shadow_latest = 64'd0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// disabled: everything is dropped
		push_evt(8'h00, 64'd50);
		push_evt(8'h00, 64'd60);
		wait_idle();

		// directed: pairs, equal start/stop, unopened stop, zero start, call and ipc runs
		write_reg(REG_ENABLE, 64'd1);
		write_reg(REG_PAIR_START, 64'h4012_1110);
		write_reg(REG_PAIR_STOP, 64'h4022_2120);
		write_reg(REG_CALL_BASE, 64'h80);
		write_reg(REG_CALL_END, 64'h7f);
		write_reg(REG_IPC_BASE, 64'ha0);
		write_reg(REG_IPC_END, 64'ha8);
		write_reg(REG_TPS, 64'd1000000);
		end_writes();
		push_evt(8'h10, 64'd100);
		push_evt(8'h20, 64'd350);
		push_evt(8'h21, 64'd400);
		push_evt(8'h10, 64'd0);
		push_evt(8'h20, 64'd500);
		push_evt(8'h40, 64'd600);
		push_evt(8'h40, 64'd700);
		push_evt(8'h80, 64'd800);
		push_evt(8'h81, 64'd900);
		push_evt(8'h9f, 64'd1000);
		push_evt(8'h7f, 64'd5000);
		push_evt(8'ha0, 64'd5100);
		push_evt(8'ha7, 64'd5200);
		push_evt(8'ha8, 64'd9000);
		push_evt(8'h11, 64'hffff_ffff_ffff_ff00);
		push_evt(8'h21, 64'h10);
		push_evt(8'h12, 64'h1);
		push_evt(8'h22, '1);
		push_evt(8'h10, 64'd10);
		push_evt(8'h20, 64'd12);
		push_evt(8'hff, 64'h5555_5555_aaaa_aaaa);
		wait_idle();

		// zero frequency with wrapping call codes
		write_reg(REG_CALL_BASE, 64'hf0);
		write_reg(REG_TPS, 64'd0);
		end_writes();
		push_random(60);
		wait_idle();

		// maximum frequency
		random_config('1);
		push_random(60);
		wait_idle();

		// one tick per second
		random_config(64'd1);
		push_random(60);
		wait_idle();

		// disable for a stretch, then re-enable
		write_reg(REG_ENABLE, 64'd0);
		end_writes();
		push_random(10);
		wait_idle();
		write_reg(REG_ENABLE, 64'd1);
		random_config({$urandom, $urandom} | 64'd1);
		push_random(50);
		wait_idle();

		random_config(64'($urandom_range(1, 100000000)));
		push_random(60);
		wait_idle();

		$display("Covered %0d events (%0d while disabled), %0d interval results checked.",
			evts_accepted, ignored_cnt, stats_seen);
		$display("Frequencies zero, one, random and maximum; %0d mismatches.", mismatch_cnt);
		if (mismatch_cnt == 0 && expected_stats_q.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// hard stop
	initial begin
		#150_000_000;
		$display("Timeout with %0d results outstanding", expected_stats_q.size());
		$display("TEST FAILED");
		$finish;
	end

endmodule

/* interval_event_profiler_unit.f */
rtl/core/iep_pkg.sv
rtl/core/iep_if.sv
rtl/core/iep_front.sv
rtl/core/iep_fifo.sv
rtl/core/iep_div.sv
rtl/core/iep_back.sv
rtl/core/interval_event_profiler_unit.sv
dv/interval_event_profiler_unit_test.sv
